// ----- hw/rtl/fpba_pkg.sv -----
`default_nettype none

package fpba_pkg;

    localparam int DEF_NUM_BLOCKS = 16;
    localparam int DEF_SIZE_WIDTH = 16;

    localparam int CMD_W    = 1;
    localparam int INDEX_W  = 4;
    localparam int VALUE_W  = 16;
    localparam int STATUS_W = 2;
    localparam int MODE_W   = 2;
    localparam int ACTIVE_W = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_LOADED = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_ALLOC  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOFIT  = 2'd2;

    localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE   = 2'd1;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;

endpackage

`default_nettype wire

// ----- hw/rtl/fit_policy_block_allocator_core.sv -----
`default_nettype none

// Block allocator with first, best and worst fit. A load's result strobe follows in the
// next cycle; busy stays low, so a new command may follow at once. An allocate over
// active entries holds busy while it scans them, and its result strobe follows the end of
// the scan: the capacity table has a single read port, and one comparator looks at one
// entry per cycle before the chosen entry is written back.
// Every result is shown for exactly one cycle on o_result_strobe and the receiver cannot stall.
module fit_policy_block_allocator_core
    import fpba_pkg::*;
#(
    parameter int NUM_BLOCKS = DEF_NUM_BLOCKS,
    parameter int SIZE_WIDTH = DEF_SIZE_WIDTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [CMD_W-1:0]      i_command,
    input  wire logic [INDEX_W-1:0]    i_block_index,
    input  wire logic [VALUE_W-1:0]    i_size_value,
    input  wire logic                  i_last_request,
    output logic                       o_result_strobe,
    output logic [STATUS_W-1:0]        o_status,
    output logic [INDEX_W-1:0]         o_chosen_block,
    output logic [VALUE_W-1:0]         o_remaining_after,
    output logic                       o_end_of_run,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic                  r_state;
    logic                  n_state;

    logic [MODE_W-1:0]     r_fit_mode;
    logic [ACTIVE_W-1:0]   r_active;

    logic [SIZE_WIDTH-1:0] r_mem [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0] r_blk_vld;

    logic [CNT_W-1:0]      r_ptr;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_q_vld;
    logic [IDX_W-1:0]      r_q_idx;
    logic [SIZE_WIDTH-1:0] r_q_data;
    logic                  r_q_bv;

    logic                  r_found;
    logic [IDX_W-1:0]      r_pick;
    logic [SIZE_WIDTH-1:0] r_best;
    logic [SIZE_WIDTH-1:0] r_size;
    logic                  r_last;

    logic                  r_strobe;
    logic [STATUS_W-1:0]   r_status;
    logic [INDEX_W-1:0]    r_chosen;
    logic [VALUE_W-1:0]    r_rem;
    logic                  r_eor;

    logic                  accept;
    logic                  load_ok;
    logic [CNT_W-1:0]      count;
    logic [SIZE_WIDTH-1:0] in_size;
    logic                  issue;
    logic                  finish;
    logic [SIZE_WIDTH-1:0] cap;
    logic                  better;
    logic                  take;
    logic [SIZE_WIDTH-1:0] left_cap;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [SIZE_WIDTH-1:0] mem_wdata;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;
    assign in_size     = SIZE_WIDTH'(i_size_value);
    assign load_ok     = (32'(i_block_index) < 32'(NUM_BLOCKS));
    assign count       = (32'(r_active) > 32'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS)
                                                            : CNT_W'(r_active);

    assign issue  = (r_state == S_SCAN) && (r_ptr < r_cnt);
    assign finish = (r_state == S_SCAN) && (r_ptr == r_cnt) && !r_q_vld;

    assign cap    = r_q_bv ? r_q_data : '0;
    assign better = ((r_fit_mode == FIT_BEST) && (cap < r_best)) ||
                    ((r_fit_mode == FIT_WORST) && (cap > r_best));
    assign take   = r_q_vld && (cap >= r_size) && (!r_found || better);

    assign left_cap = r_best - r_size;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_pick;
        mem_wdata = left_cap;
        if (accept && (i_command == CMD_LOAD) && load_ok) begin
            mem_we    = 1'b1;
            mem_waddr = IDX_W'(i_block_index);
            mem_wdata = in_size;
        end else if (finish && r_found) begin
            mem_we = 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_command == CMD_ALLOC) && (count != '0)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (finish) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_fit_mode <= FIT_FIRST;
            r_active   <= ACTIVE_RESET;
            r_blk_vld  <= '0;
            r_q_vld    <= 1'b0;
            r_found    <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_q_vld  <= issue;
            r_strobe <= (accept && !(i_command == CMD_ALLOC && count != '0)) || finish;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_FIT_MODE: r_fit_mode <= MODE_W'(i_cfg_data);
                    CFG_ACTIVE:   r_active   <= ACTIVE_W'(i_cfg_data);
                    default:      ;
                endcase
            end
            if (mem_we) begin
                r_blk_vld[mem_waddr] <= 1'b1;
            end
            if (accept) begin
                r_found <= 1'b0;
            end else if (take) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (issue) begin
            r_q_data <= r_mem[r_ptr[IDX_W-1:0]];
            r_q_bv   <= r_blk_vld[r_ptr[IDX_W-1:0]];
            r_q_idx  <= r_ptr[IDX_W-1:0];
            r_ptr    <= r_ptr + CNT_W'(1);
        end
        if (take) begin
            r_pick <= r_q_idx;
            r_best <= cap;
        end
        if (accept) begin
            r_ptr  <= '0;
            r_cnt  <= count;
            r_size <= in_size;
            r_last <= i_last_request;
            r_eor  <= i_last_request;
            if (i_command == CMD_LOAD) begin
                r_status <= STAT_LOADED;
                r_chosen <= '0;
                r_rem    <= load_ok ? VALUE_W'(in_size) : '0;
            end else begin
                r_status <= STAT_NOFIT;
                r_chosen <= '0;
                r_rem    <= '0;
            end
        end else if (finish) begin
            r_eor <= r_last;
            if (r_found) begin
                r_status <= STAT_ALLOC;
                r_chosen <= INDEX_W'(r_pick);
                r_rem    <= VALUE_W'(left_cap);
            end else begin
                r_status <= STAT_NOFIT;
                r_chosen <= '0;
                r_rem    <= '0;
            end
        end
    end

    assign o_result_strobe   = r_strobe;
    assign o_status          = r_status;
    assign o_chosen_block    = r_chosen;
    assign o_remaining_after = r_rem;
    assign o_end_of_run      = r_eor;

    a_alloc_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_command == CMD_ALLOC) && (count != '0)) |=> busy)
        else $error("Allocate with active entries did not start a scan.");

    a_no_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_result_strobe)
        else $error("Result strobe raised during a scan.");

    a_pick_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && r_found) |-> (32'(r_pick) < 32'(r_cnt)))
        else $error("Chosen entry lies outside the active range.");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && r_q_vld) |-> (32'(r_q_idx) < 32'(r_cnt)))
        else $error("Scan read an entry outside the active range.");

endmodule

`default_nettype wire

// ----- sim/fpba_checker.sv -----
module fpba_checker
    import fpba_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic                  i_busy,
    input  wire logic [CMD_W-1:0]      i_command,
    input  wire logic [INDEX_W-1:0]    i_block_index,
    input  wire logic [VALUE_W-1:0]    i_size_value,
    input  wire logic                  i_last_request,
    input  wire logic                  i_result_strobe,
    input  wire logic [STATUS_W-1:0]   i_status,
    input  wire logic [INDEX_W-1:0]    i_chosen_block,
    input  wire logic [VALUE_W-1:0]    i_remaining_after,
    input  wire logic                  i_end_of_run,
    input  wire logic                  i_cfg_valid,
    input  wire logic                  i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                         o_errors,
    output int                         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = DEF_NUM_BLOCKS;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  chosen;
        logic [VALUE_W-1:0]  remaining;
        logic                end_of_run;
    } t_alloc_reply;

    logic [VALUE_W-1:0]  capacity_table [TABLE_DEPTH];
    logic [MODE_W-1:0]   fit_rule;
    logic [ACTIVE_W-1:0] active_count;
    t_alloc_reply        reply_queue [$];
    int                  fail_count = 0;
    int                  pending_count = 0;

    assign o_errors  = fail_count;
    assign o_pending = pending_count;

    task automatic report_failure(input string msg);
        $display("[%0t] checker: %s", $time, msg);
        fail_count++;
    endtask

    function automatic t_alloc_reply serve_command(
        input logic [CMD_W-1:0]   cmd,
        input logic [INDEX_W-1:0] idx,
        input logic [VALUE_W-1:0] size,
        input logic               last
    );
        t_alloc_reply r;
        int span;
        int pick;
        int j;
        bit found;
        r.status     = STAT_LOADED;
        r.chosen     = '0;
        r.remaining  = '0;
        r.end_of_run = last;
        if (cmd == CMD_LOAD) begin
            if (int'(idx) < TABLE_DEPTH) begin
                capacity_table[idx] = size;
                r.remaining = size;
            end
        end else begin
            span  = (int'(active_count) > TABLE_DEPTH) ? TABLE_DEPTH : int'(active_count);
            found = 1'b0;
            pick  = 0;
            for (j = 0; j < span; j++) begin
                if (capacity_table[j] >= size) begin
                    if (!found) begin
                        found = 1'b1;
                        pick  = j;
                    end else if (fit_rule == FIT_BEST
                                 && capacity_table[j] < capacity_table[pick]) begin
                        pick = j;
                    end else if (fit_rule == FIT_WORST
                                 && capacity_table[j] > capacity_table[pick]) begin
                        pick = j;
                    end
                end
            end
            if (found) begin
                capacity_table[pick] = capacity_table[pick] - size;
                r.status    = STAT_ALLOC;
                r.chosen    = INDEX_W'(pick);
                r.remaining = capacity_table[pick];
            end else begin
                r.status = STAT_NOFIT;
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_alloc_reply want;
        if (!i_rst_n) begin
            foreach (capacity_table[k]) begin
                capacity_table[k] = '0;
            end
            fit_rule     = FIT_FIRST;
            active_count = ACTIVE_RESET;
            reply_queue.delete();
        end else begin
            // Results are matched before new commands are queued so a stray strobe
            // can never consume the expectation of a command taken at the same edge.
            if (i_result_strobe) begin
                if (reply_queue.size() == 0) begin
                    report_failure($sformatf("result with no command pending (status %0d)",
                                             i_status));
                end else begin
                    want = reply_queue.pop_front();
                    if (i_status !== want.status)
                        report_failure($sformatf("status got %0d expected %0d",
                                                 i_status, want.status));
                    if (i_chosen_block !== want.chosen)
                        report_failure($sformatf("chosen_block got %0d expected %0d",
                                                 i_chosen_block, want.chosen));
                    if (i_remaining_after !== want.remaining)
                        report_failure($sformatf("remaining_after got %0d expected %0d",
                                                 i_remaining_after, want.remaining));
                    if (i_end_of_run !== want.end_of_run)
                        report_failure($sformatf("end_of_run got %0d expected %0d",
                                                 i_end_of_run, want.end_of_run));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_FIT_MODE) begin
                    fit_rule = i_cfg_data[MODE_W-1:0];
                end else if (i_cfg_index == CFG_ACTIVE) begin
                    active_count = i_cfg_data[ACTIVE_W-1:0];
                end
            end
            if (i_start && !i_busy) begin
                reply_queue.push_back(serve_command(i_command, i_block_index,
                                                    i_size_value, i_last_request));
            end
        end
        pending_count <= reply_queue.size();
    end

endmodule

// ----- sim/testbench.sv -----
module testbench;
    import fpba_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASES = 12;
    localparam int MIXED_PER_PHASE = 72;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [CMD_W-1:0]      command = CMD_LOAD;
    logic [INDEX_W-1:0]    block_index = '0;
    logic [VALUE_W-1:0]    size_value = '0;
    logic                  last_request = 1'b0;
    logic                  result_strobe;
    logic [STATUS_W-1:0]   status;
    logic [INDEX_W-1:0]    chosen_block;
    logic [VALUE_W-1:0]    remaining_after;
    logic                  end_of_run;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    errors;
    int                    pending;
    int                    cycles = 0;

    always #5 clk = ~clk;

    fit_policy_block_allocator_core u_top (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .start             (start),
        .busy              (busy),
        .i_command         (command),
        .i_block_index     (block_index),
        .i_size_value      (size_value),
        .i_last_request    (last_request),
        .o_result_strobe   (result_strobe),
        .o_status          (status),
        .o_chosen_block    (chosen_block),
        .o_remaining_after (remaining_after),
        .o_end_of_run      (end_of_run),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data)
    );

    fpba_checker u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_start           (start),
        .i_busy            (busy),
        .i_command         (command),
        .i_block_index     (block_index),
        .i_size_value      (size_value),
        .i_last_request    (last_request),
        .i_result_strobe   (result_strobe),
        .i_status          (status),
        .i_chosen_block    (chosen_block),
        .i_remaining_after (remaining_after),
        .i_end_of_run      (end_of_run),
        .i_cfg_valid       (cfg_valid),
        .i_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .o_errors          (errors),
        .o_pending         (pending)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_command(
        input logic [CMD_W-1:0]   cmd,
        input logic [INDEX_W-1:0] idx,
        input logic [VALUE_W-1:0] size,
        input logic               last
    );
        @(negedge clk);
        start        = 1'b1;
        command      = cmd;
        block_index  = idx;
        size_value   = size;
        last_request = last;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic hold_off(input int n);
        if (n > 0) begin
            @(negedge clk);
            start = 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_register(
        input logic [CFG_IDX_W-1:0]  idx,
        input logic [CFG_DATA_W-1:0] data
    );
        wait_drained();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic int pick_gap(input bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_capacity();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return VALUE_W'($urandom_range(0, 2000));
        if (r < 9) return VALUE_W'($urandom);
        return ($urandom_range(0, 1) == 1) ? '1 : '0;
    endfunction

    initial begin
        int mode;
        int active;
        int r;
        bit steady;
        logic [VALUE_W-1:0] req;

        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        send_command(CMD_ALLOC, 4'd0, 16'd0, 1'b0);
        send_command(CMD_ALLOC, 4'd0, 16'd1, 1'b1);
        send_command(CMD_LOAD, 4'd15, 16'hFFFF, 1'b1);
        send_command(CMD_LOAD, 4'd0, 16'd0, 1'b0);
        send_command(CMD_LOAD, 4'd3, 16'd100, 1'b0);
        send_command(CMD_LOAD, 4'd7, 16'd300, 1'b0);
        send_command(CMD_LOAD, 4'd9, 16'd200, 1'b0);
        send_command(CMD_ALLOC, 4'd0, 16'hFFFF, 1'b0);
        send_command(CMD_ALLOC, 4'd0, 16'd150, 1'b1);
        write_register(CFG_FIT_MODE, CFG_DATA_W'(FIT_BEST));
        send_command(CMD_ALLOC, 4'd0, 16'd120, 1'b0);
        send_command(CMD_ALLOC, 4'd0, 16'd0, 1'b0);
        write_register(CFG_FIT_MODE, CFG_DATA_W'(FIT_WORST));
        send_command(CMD_LOAD, 4'd5, 16'd200, 1'b0);
        send_command(CMD_ALLOC, 4'd0, 16'd50, 1'b0);
        write_register(CFG_FIT_MODE, CFG_DATA_W'(3));
        send_command(CMD_ALLOC, 4'd0, 16'd10, 1'b0);
        write_register(CFG_ACTIVE, CFG_DATA_W'(0));
        send_command(CMD_ALLOC, 4'd0, 16'd0, 1'b1);
        write_register(CFG_ACTIVE, CFG_DATA_W'(31));
        write_register(CFG_FIT_MODE, CFG_DATA_W'(FIT_WORST));
        send_command(CMD_LOAD, 4'd15, 16'hFFFF, 1'b0);
        send_command(CMD_ALLOC, 4'd0, 16'd1, 1'b0);
        write_register(CFG_ACTIVE, CFG_DATA_W'(1));
        send_command(CMD_ALLOC, 4'd0, 16'd0, 1'b0);
        send_command(CMD_ALLOC, 4'd0, 16'd1, 1'b0);
        write_register(CFG_ACTIVE, CFG_DATA_W'(17));
        write_register(CFG_FIT_MODE, CFG_DATA_W'(FIT_BEST));
        send_command(CMD_LOAD, 4'd10, 16'hAAAA, 1'b1);
        send_command(CMD_LOAD, 4'd4, 16'h5555, 1'b0);
        send_command(CMD_ALLOC, 4'd0, 16'h5555, 1'b1);

        for (int p = 0; p < PHASES; p++) begin
            mode = $urandom_range(0, 3);
            r = $urandom_range(0, 19);
            if (r < 12) active = $urandom_range(2, 16);
            else if (r < 15) active = 16;
            else if (r < 17) active = 1;
            else if (r < 19) active = $urandom_range(17, 31);
            else active = 0;
            write_register(CFG_FIT_MODE, CFG_DATA_W'(mode));
            write_register(CFG_ACTIVE, CFG_DATA_W'(active));
            steady = ($urandom_range(0, 3) == 0);

            // Fill most of the table so that the searches see several candidates.
            for (int b = 0; b < DEF_NUM_BLOCKS; b++) begin
                if ($urandom_range(0, 4) != 0) begin
                    send_command(CMD_LOAD, INDEX_W'(b), pick_capacity(), 1'($urandom));
                    hold_off(pick_gap(steady));
                end
            end

            for (int k = 0; k < MIXED_PER_PHASE; k++) begin
                if ($urandom_range(0, 9) < 3) begin
                    send_command(CMD_LOAD, INDEX_W'($urandom_range(0, 15)), pick_capacity(),
                                 1'($urandom));
                end else begin
                    r = $urandom_range(0, 19);
                    if (r < 12) req = VALUE_W'($urandom_range(1, 500));
                    else if (r < 15) req = '0;
                    else if (r < 18) req = VALUE_W'($urandom);
                    else req = '1;
                    send_command(CMD_ALLOC, INDEX_W'($urandom_range(0, 15)), req,
                                 1'($urandom));
                end
                hold_off(pick_gap(steady));
            end
        end

        wait_drained();
        repeat (20) @(negedge clk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
